>>> rtl/kle_pkg.sv
// Shared constants, types and codes for the keystroke line editor.
package kle_pkg;

  // Text capacity and derived widths
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 8;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Key codes
  localparam logic [KEY_W-1:0] KEY_LEFT   = 8'd60;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'd62;
  localparam logic [KEY_W-1:0] KEY_DELETE = 8'd45;

  // Operation field codes
  localparam logic OP_KEY = 1'b0;
  localparam logic OP_EOL = 1'b1;

  typedef enum logic [2:0] {
    CMD_INSERT,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_DELETE,
    CMD_EOL
  } kle_cmd_op_t;

  typedef struct packed {
    kle_cmd_op_t      op;
    logic [KEY_W-1:0] key;
  } kle_cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
  } kle_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE_L,
    ST_MOVE_R,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_EMPTY
  } kle_state_t;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
  } kle_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] char_out;
    logic             is_empty;
    logic             last_char;
    logic             overflowed;
  } kle_out_t;

endpackage

>>> rtl/kle_front.sv
// Front end: accepts input transfers and classifies them into editor commands.
module kle_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  kle_pkg::kle_in_t  in_data,
  input  kle_pkg::kle_qstat_t q_stat,
  output logic              push,
  output kle_pkg::kle_cmd_t push_cmd
);
  import kle_pkg::*;

  // Stall only on a full queue
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Decode the key into a command
  always_comb begin
    push_cmd.key = in_data.key;
    if (in_data.operation == OP_EOL) begin
      push_cmd.op = CMD_EOL;
    end else begin
      case (in_data.key)
        KEY_LEFT:   push_cmd.op = CMD_LEFT;
        KEY_RIGHT:  push_cmd.op = CMD_RIGHT;
        KEY_DELETE: push_cmd.op = CMD_DELETE;
        default:    push_cmd.op = CMD_INSERT;
      endcase
    end
  end

endmodule

>>> rtl/kle_queue.sv
// Short command queue that decouples the front end from the edit engine.
module kle_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  kle_pkg::kle_cmd_t   push_cmd,
  output kle_pkg::kle_qstat_t q_stat,
  input  logic                pop,
  output logic                q_valid,
  output kle_pkg::kle_cmd_t   q_cmd
);
  import kle_pkg::*;

  kle_cmd_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign q_valid     = (cnt_r != '0);
  assign q_stat.full = (cnt_r == QCNT_W'(QDEPTH));
  assign q_cmd       = slot_r[rd_ptr_r];
  assign do_pop      = pop && q_valid;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/kle_back.sv
// Edit engine: runs commands on the two character stacks and streams lines out.
module kle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  kle_pkg::kle_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output kle_pkg::kle_out_t out_data
);
  import kle_pkg::*;

  // Stack memories
  logic [KEY_W-1:0]  left_mem  [CAPACITY];
  logic [KEY_W-1:0]  right_mem [CAPACITY];
  logic [KEY_W-1:0]  l_rd_q, r_rd_q;

  kle_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  lc_r, lc_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              ovf_r, ovf_nxt;
  kle_out_t          out_r, out_nxt;
  logic              out_vld_r;
  logic              out_load;

  logic              l_we, r_we, l_re, r_re;
  logic [ADDR_W-1:0] l_waddr, r_waddr, l_raddr, r_raddr;
  logic [KEY_W-1:0]  l_wdata, r_wdata;

  logic [CNT_W-1:0]  total, total_m1, lc_m1, rc_m1, rev_pos;
  logic              mv_l_ok, mv_r_ok, full, from_left, is_last, out_free;

  assign total     = lc_r + rc_r;
  assign total_m1  = total - CNT_W'(1);
  assign lc_m1     = lc_r - CNT_W'(1);
  assign rc_m1     = rc_r - CNT_W'(1);
  assign rev_pos   = total_m1 - pos_r;
  assign full      = (total >= CNT_W'(CAPACITY));
  assign mv_l_ok   = (lc_r != '0) && (rc_r < CNT_W'(CAPACITY));
  assign mv_r_ok   = (rc_r != '0) && (lc_r < CNT_W'(CAPACITY));
  assign from_left = (pos_r < lc_r);
  assign is_last   = (pos_r == total_m1);
  assign out_free  = !out_vld_r || !out_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            CMD_LEFT:  state_nxt = mv_l_ok ? ST_MOVE_L : ST_IDLE;
            CMD_RIGHT: state_nxt = mv_r_ok ? ST_MOVE_R : ST_IDLE;
            CMD_EOL:   state_nxt = (total == '0) ? ST_EMIT_EMPTY : ST_EMIT_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MOVE_L, ST_MOVE_R: state_nxt = ST_IDLE;
      ST_EMIT_RD:           state_nxt = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free) begin
          state_nxt = is_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMIT_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    q_pop    = 1'b0;
    l_we     = 1'b0;
    r_we     = 1'b0;
    l_re     = 1'b0;
    r_re     = 1'b0;
    l_waddr  = lc_r[ADDR_W-1:0];
    r_waddr  = rc_r[ADDR_W-1:0];
    l_wdata  = q_cmd.key;
    r_wdata  = l_rd_q;
    l_raddr  = lc_m1[ADDR_W-1:0];
    r_raddr  = rc_m1[ADDR_W-1:0];
    lc_nxt   = lc_r;
    rc_nxt   = rc_r;
    ovf_nxt  = ovf_r;
    pos_nxt  = pos_r;
    out_load = 1'b0;
    out_nxt  = out_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            CMD_INSERT: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                l_we   = 1'b1;
                lc_nxt = lc_r + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              if (lc_r != '0) begin
                lc_nxt = lc_m1;
              end
            end
            CMD_LEFT: begin
              if (mv_l_ok) begin
                l_re   = 1'b1;
                lc_nxt = lc_m1;
              end
            end
            CMD_RIGHT: begin
              if (mv_r_ok) begin
                r_re   = 1'b1;
                rc_nxt = rc_m1;
              end
            end
            CMD_EOL: pos_nxt = '0;
            default: q_pop = 1'b1;
          endcase
        end
      end
      // Second half of a cursor move: push the popped character
      ST_MOVE_L: begin
        r_we    = 1'b1;
        r_wdata = l_rd_q;
        rc_nxt  = rc_r + CNT_W'(1);
      end
      ST_MOVE_R: begin
        l_we    = 1'b1;
        l_wdata = r_rd_q;
        lc_nxt  = lc_r + CNT_W'(1);
      end
      // Left stack bottom-up, then right stack top-down
      ST_EMIT_RD: begin
        if (from_left) begin
          l_re    = 1'b1;
          l_raddr = pos_r[ADDR_W-1:0];
        end else begin
          r_re    = 1'b1;
          r_raddr = rev_pos[ADDR_W-1:0];
        end
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_nxt.char_out   = from_left ? l_rd_q : r_rd_q;
          out_nxt.is_empty   = 1'b0;
          out_nxt.last_char  = is_last;
          out_nxt.overflowed = ovf_r;
          pos_nxt            = pos_r + CNT_W'(1);
          if (is_last) begin
            lc_nxt  = '0;
            rc_nxt  = '0;
            ovf_nxt = 1'b0;
          end
        end
      end
      ST_EMIT_EMPTY: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_nxt.char_out   = '0;
          out_nxt.is_empty   = 1'b1;
          out_nxt.last_char  = 1'b1;
          out_nxt.overflowed = ovf_r;
          ovf_nxt            = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      lc_r      <= '0;
      rc_r      <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      rc_r    <= rc_nxt;
      ovf_r   <= ovf_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  // Stack memories, registered read
  always_ff @(posedge clk) begin
    if (l_we) begin
      left_mem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      l_rd_q <= left_mem[l_raddr];
    end
    if (r_we) begin
      right_mem[r_waddr] <= r_wdata;
    end
    if (r_re) begin
      r_rd_q <= right_mem[r_raddr];
    end
  end

endmodule

>>> rtl/keystroke_line_editor_unit.sv
// Top level of the keystroke line editor.
//
// Input channel in_valid/in_stall/in_data carries keystrokes (operation 0)
// and end-of-line items (operation 1). Result channel out_valid/out_stall/
// out_data carries the finished line one character per transfer, last_char
// on the final one; an empty line gives one transfer with is_empty set.
// A four-entry command queue sits between the front end and the edit engine,
// so keystrokes are taken back to back until it fills.
// Insert and delete finish in the engine's idle state; a cursor move also
// passes through a move state (the stack memories have a registered read
// port, so a move is a read followed by a write). An end-of-line item
// emits each character through a read state and a load state, set by the
// same read port.
// Reset (rst_n low, synchronous) empties the queue and the text and clears
// the overflow mark; stack contents are not cleared and need no sweep.
// When the receiver stalls, the output register holds its transfer and the
// engine waits; the queue keeps taking input until full, then in_stall rises.
module keystroke_line_editor_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kle_pkg::kle_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kle_pkg::kle_out_t out_data
);
  import kle_pkg::*;

  logic       push, q_pop, q_valid;
  kle_cmd_t   push_cmd, q_cmd;
  kle_qstat_t q_stat;

  kle_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  kle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  kle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/kle_checker.sv
// Port-level checks for the keystroke line editor, bound to the top level.
module kle_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input kle_pkg::kle_out_t out_data
);
  import kle_pkg::*;

  // A stalled result transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An empty line is a single zero transfer that closes the line
  a_empty_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.last_char && (out_data.char_out == '0))
    else $error("empty line transfer malformed");

  // The overflow mark is constant across one line
  a_ovf_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_char ##1 out_valid
      |-> out_data.overflowed == $past(out_data.overflowed))
    else $error("overflow mark changed within a line");

endmodule

bind keystroke_line_editor_unit kle_checker u_kle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/line_editor_checker.sv
`timescale 1ns / 100ps
// Watches both channels of the line editor, predicts every finished line and checks it.
module line_editor_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  kle_pkg::kle_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  kle_pkg::kle_out_t out_data,
  output int unsigned       chars_owed,
  output int unsigned       mismatches
);
  import kle_pkg::*;

  // Text either side of the cursor; right_text has the char next to the cursor on top
  logic [KEY_W-1:0] left_text  [CAPACITY];
  logic [KEY_W-1:0] right_text [CAPACITY];
  int unsigned      left_len;
  int unsigned      right_len;
  logic             line_overflow;

  // Characters still to come out, oldest first
  kle_out_t         owed_chars [$];
  kle_out_t         wanted;
  int unsigned      fail_count = 0;

  assign mismatches = fail_count;

  // Apply one keystroke to the text
  task automatic edit_text(input logic [KEY_W-1:0] key);
    case (key)
      KEY_LEFT: begin
        if (left_len > 0 && right_len < CAPACITY) begin
          left_len--;
          right_text[right_len] = left_text[left_len];
          right_len++;
        end
      end
      KEY_RIGHT: begin
        if (right_len > 0 && left_len < CAPACITY) begin
          right_len--;
          left_text[left_len] = right_text[right_len];
          left_len++;
        end
      end
      KEY_DELETE: begin
        if (left_len > 0) left_len--;
      end
      default: begin
        // full buffer: key is dropped, line marked
        if (left_len + right_len >= CAPACITY) line_overflow = 1'b1;
        else begin
          left_text[left_len] = key;
          left_len++;
        end
      end
    endcase
  endtask

  // End of line: queue the whole text in order, then clear it
  task automatic flush_line();
    int unsigned total;
    kle_out_t    ch;
    total = left_len + right_len;
    ch.overflowed = line_overflow;
    if (total == 0) begin
      ch.char_out  = '0;
      ch.is_empty  = 1'b1;
      ch.last_char = 1'b1;
      owed_chars.insert(owed_chars.size(), ch);
    end else begin
      ch.is_empty = 1'b0;
      for (int unsigned n = 0; n < total; n++) begin
        ch.char_out  = (n < left_len) ? left_text[n] : right_text[total - 1 - n];
        ch.last_char = (n + 1 == total);
        owed_chars.insert(owed_chars.size(), ch);
      end
    end
    left_len      = 0;
    right_len     = 0;
    line_overflow = 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side first, so a line accepted at this edge cannot absorb an older transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      left_len      = 0;
      right_len     = 0;
      line_overflow = 1'b0;
      owed_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_chars.size() == 0) begin
          $error("result transfer with nothing owed: char_out %0h", out_data.char_out);
          fail_count++;
        end else begin
          wanted = owed_chars[0];
          owed_chars.delete(0);
          compare_field("char_out", wanted.char_out, out_data.char_out);
          compare_field("is_empty", wanted.is_empty, out_data.is_empty);
          compare_field("last_char", wanted.last_char, out_data.last_char);
          compare_field("overflowed", wanted.overflowed, out_data.overflowed);
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_EOL) flush_line();
        else edit_text(in_data.key);
      end
    end
    chars_owed <= owed_chars.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the line editor testbench: clock, reset, keystroke stimulus and verdict.
module testbench;
  import kle_pkg::*;

  // Worst case is far below this: a few hundred items and results,
  // each delayed by an input gap or receiver stall plus engine work
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 220;
  localparam int QUIET_FROM   = 180;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  kle_in_t     in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  kle_out_t    out_data;

  int unsigned chars_owed;
  int unsigned mismatches;
  int          idle_rate  = 0;   // 0: no idling, else 1 in idle_rate chance per cycle
  int          stall_left = 0;
  int          cycle_count = 0;
  int          items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keystroke_line_editor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  line_editor_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .chars_owed (chars_owed),
    .mismatches (mismatches)
  );

  // Receiver stalls in bursts of random length while idle_rate is nonzero
  always @(posedge clk) begin
    if (idle_rate == 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(1, idle_rate) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // One transfer on the input channel, with an occasional gap in front of it
  task automatic send(input logic op, input logic [KEY_W-1:0] key);
    kle_in_t item;
    int      gap;
    item.operation = op;
    item.key       = key;
    if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [KEY_W-1:0] plain_char();
    logic [KEY_W-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == KEY_LEFT || c == KEY_RIGHT || c == KEY_DELETE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Hold off input until every owed character has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
  endtask

  // A line of len keystrokes, insert_pct percent of them inserts, then end of line
  task automatic typed_line(input int len, input int insert_pct);
    int pick;
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct)                      send(OP_KEY, 8'($urandom_range(0, 255)));
      else if (pick < insert_pct + (100 - insert_pct) / 3) send(OP_KEY, KEY_LEFT);
      else if (pick < insert_pct + 2 * (100 - insert_pct) / 3) send(OP_KEY, KEY_RIGHT);
      else                                        send(OP_KEY, KEY_DELETE);
    end
    send(OP_EOL, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int kind;
    repeat (9) @(posedge clk);
    rst_n     <= 1'b1;
    idle_rate <= 4;

    // Directed: empty lines, moves and delete at the ends, byte extremes
    send(OP_EOL, 8'h00);
    send(OP_KEY, KEY_LEFT);
    send(OP_KEY, KEY_RIGHT);
    send(OP_KEY, KEY_DELETE);
    send(OP_EOL, 8'hFF);
    send(OP_KEY, 8'h2C);
    send(OP_EOL, 8'h00);
    send(OP_KEY, 8'h00);
    send(OP_KEY, 8'hFF);
    send(OP_KEY, 8'h41);
    send(OP_KEY, KEY_LEFT);
    send(OP_KEY, KEY_LEFT);
    send(OP_KEY, KEY_DELETE);
    send(OP_KEY, 8'h7E);
    send(OP_KEY, KEY_LEFT);
    send(OP_KEY, KEY_LEFT);
    send(OP_KEY, KEY_LEFT);
    send(OP_KEY, KEY_DELETE);
    send(OP_KEY, KEY_RIGHT);
    send(OP_KEY, KEY_RIGHT);
    send(OP_KEY, KEY_RIGHT);
    send(OP_KEY, KEY_RIGHT);
    send(OP_EOL, 8'hA5);
    drain();

    // Full buffer: fill past capacity with some cursor moves, then delete and insert
    for (int n = 0; n < CAPACITY + 4; n++) begin
      if ($urandom_range(0, 9) == 0) send(OP_KEY, KEY_LEFT);
      send(OP_KEY, plain_char());
    end
    send(OP_KEY, KEY_DELETE);
    send(OP_KEY, plain_char());
    send(OP_EOL, 8'h5A);

    // Random lines, mostly short, a few long, some loose noise
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= QUIET_FROM) idle_rate <= 0;
      else idle_rate <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        repeat ($urandom_range(3, 12)) send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (kind == 1) begin
        typed_line($urandom_range(50, 80), 85);
      end else begin
        typed_line($urandom_range(0, 12), $urandom_range(40, 80));
      end
      if (kind == 2 && items_sent > RANDOM_ITEMS / 2 && items_sent < QUIET_FROM) drain();
    end

    // Let the last line out and give the engine time to finish
    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && chars_owed == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
